@@ rtl/fcvl_pkg.sv @@
// ----------------------------------------------------------------------------
// fcvl_pkg
// Shared types, constants and fixed-point helpers for the dq decoupling
// and voltage limit block.
// ----------------------------------------------------------------------------
package fcvl_pkg;

    localparam int DATA_WIDTH = 24;
    localparam int FRAC_BITS  = 20;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int WIDE_WIDTH = PROD_WIDTH - FRAC_BITS;
    localparam int ROOT_WIDTH = DATA_WIDTH;
    localparam int REM_WIDTH  = ROOT_WIDTH + 3;
    localparam int CELL_COUNT = ROOT_WIDTH;
    localparam int FRONT_STAGES = 5;
    localparam int STAGE_COUNT  = FRONT_STAGES + CELL_COUNT + 1;

    localparam logic signed [WIDE_WIDTH-1:0] SAT_HI =
        WIDE_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [WIDE_WIDTH-1:0] SAT_LO = -SAT_HI - WIDE_WIDTH'(1);

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [MAG_WIDTH-1:0]         mag_t;

    typedef enum logic [1:0] {
        REG_FLUX_GAIN  = 2'd0,
        REG_CROSS_GAIN = 2'd1,
        REG_SLIP_GAIN  = 2'd2
    } reg_index_t;

    typedef struct packed {
        word_t usd;
        word_t usq;
        mag_t  lim;
        logic  ovl;
        logic  dclamp;
    } meta_t;

    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
        logic [PROD_WIDTH-1:0] x;
        meta_t                 meta;
    } cell_t;

    function automatic word_t sat_wide(input logic signed [WIDE_WIDTH-1:0] v);
        word_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WIDE_WIDTH-1:0] sext_word(input word_t v);
        return WIDE_WIDTH'(v);
    endfunction

    // Product floored to the fixed-point scale, then saturated.
    function automatic word_t fmul(input word_t a, input word_t b);
        logic signed [PROD_WIDTH-1:0] p;
        p = PROD_WIDTH'(a) * PROD_WIDTH'(b);
        return sat_wide(signed'(p[PROD_WIDTH-1:FRAC_BITS]));
    endfunction

endpackage

@@ rtl/fcvl_front.sv @@
// ----------------------------------------------------------------------------
// fcvl_front
// Compensation, squaring and limit decision pipeline that prepares the
// square-root operand for the cell row.
// ----------------------------------------------------------------------------
module fcvl_front (
    input  logic                                 clk,
    input  logic [fcvl_pkg::FRONT_STAGES-1:0]    en,
    input  fcvl_pkg::word_t                      flux_gain,
    input  fcvl_pkg::word_t                      cross_gain,
    input  fcvl_pkg::word_t                      slip_gain,
    input  fcvl_pkg::word_t                      ref_volt_d,
    input  fcvl_pkg::word_t                      ref_volt_q,
    input  fcvl_pkg::word_t                      cur_d,
    input  fcvl_pkg::word_t                      cur_q,
    input  fcvl_pkg::word_t                      flux_cur,
    input  fcvl_pkg::word_t                      elec_speed,
    input  fcvl_pkg::word_t                      slip_speed,
    input  fcvl_pkg::mag_t                       volt_limit,
    output fcvl_pkg::cell_t                      cell_out
);

    fcvl_pkg::word_t s1_flux_reg, s1_wq_reg, s1_wd_reg, s1_wf_reg;
    fcvl_pkg::word_t s1_urd_reg, s1_urq_reg;
    fcvl_pkg::mag_t  s1_lim_reg;

    fcvl_pkg::word_t s2_flux_reg, s2_x_reg, s2_y_reg, s2_z_reg;
    fcvl_pkg::word_t s2_urd_reg, s2_urq_reg;
    fcvl_pkg::mag_t  s2_lim_reg;

    fcvl_pkg::word_t s3_usd_reg, s3_usq_reg;
    fcvl_pkg::mag_t  s3_lim_reg;

    fcvl_pkg::word_t s4_usd_reg, s4_usq_reg;
    fcvl_pkg::mag_t  s4_lim_reg;
    logic [fcvl_pkg::DATA_WIDTH-1:0] s4_ad_reg;
    logic [fcvl_pkg::PROD_WIDTH-1:0] s4_ad2_reg, s4_aq2_reg, s4_l2_reg;

    fcvl_pkg::cell_t s5_reg;

    fcvl_pkg::word_t ucd, ucq, usd_next, usq_next;
    logic [fcvl_pkg::DATA_WIDTH-1:0] ad, aq;
    logic [fcvl_pkg::PROD_WIDTH-1:0] sum_sq, l2_minus;
    logic ovl, dclamp;

    always_comb
    begin
        ucd = fcvl_pkg::sat_wide(fcvl_pkg::sext_word(s2_flux_reg)
                                 + fcvl_pkg::sext_word(s2_x_reg));
        ucq = fcvl_pkg::sat_wide(-fcvl_pkg::sext_word(s2_y_reg)
                                 - fcvl_pkg::sext_word(s2_z_reg));
        usd_next = fcvl_pkg::sat_wide(fcvl_pkg::sext_word(s2_urd_reg)
                                      - fcvl_pkg::sext_word(ucd));
        usq_next = fcvl_pkg::sat_wide(fcvl_pkg::sext_word(s2_urq_reg)
                                      - fcvl_pkg::sext_word(ucq));
        ad = s3_usd_reg[fcvl_pkg::DATA_WIDTH-1] ? 24'(-s3_usd_reg) : 24'(s3_usd_reg);
        aq = s3_usq_reg[fcvl_pkg::DATA_WIDTH-1] ? 24'(-s3_usq_reg) : 24'(s3_usq_reg);
        sum_sq   = s4_ad2_reg + s4_aq2_reg;
        l2_minus = s4_l2_reg - s4_ad2_reg;
        ovl      = sum_sq > s4_l2_reg;
        dclamp   = s4_ad_reg >= {1'b0, s4_lim_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_flux_reg <= fcvl_pkg::fmul(flux_gain, flux_cur);
            s1_wq_reg   <= fcvl_pkg::fmul(elec_speed, cur_q);
            s1_wd_reg   <= fcvl_pkg::fmul(elec_speed, cur_d);
            s1_wf_reg   <= fcvl_pkg::fmul(slip_speed, flux_cur);
            s1_urd_reg  <= ref_volt_d;
            s1_urq_reg  <= ref_volt_q;
            s1_lim_reg  <= volt_limit;
        end
        if (en[1])
        begin
            s2_flux_reg <= s1_flux_reg;
            s2_x_reg    <= fcvl_pkg::fmul(s1_wq_reg, cross_gain);
            s2_y_reg    <= fcvl_pkg::fmul(s1_wd_reg, cross_gain);
            s2_z_reg    <= fcvl_pkg::fmul(s1_wf_reg, slip_gain);
            s2_urd_reg  <= s1_urd_reg;
            s2_urq_reg  <= s1_urq_reg;
            s2_lim_reg  <= s1_lim_reg;
        end
        if (en[2])
        begin
            s3_usd_reg <= usd_next;
            s3_usq_reg <= usq_next;
            s3_lim_reg <= s2_lim_reg;
        end
        if (en[3])
        begin
            s4_usd_reg <= s3_usd_reg;
            s4_usq_reg <= s3_usq_reg;
            s4_lim_reg <= s3_lim_reg;
            s4_ad_reg  <= ad;
            s4_ad2_reg <= ad * ad;
            s4_aq2_reg <= aq * aq;
            s4_l2_reg  <= 48'(s3_lim_reg) * 48'(s3_lim_reg);
        end
        if (en[4])
        begin
            s5_reg.rem         <= '0;
            s5_reg.root        <= '0;
            s5_reg.x           <= !ovl ? sum_sq : (dclamp ? '0 : l2_minus);
            s5_reg.meta.usd    <= s4_usd_reg;
            s5_reg.meta.usq    <= s4_usq_reg;
            s5_reg.meta.lim    <= s4_lim_reg;
            s5_reg.meta.ovl    <= ovl;
            s5_reg.meta.dclamp <= dclamp;
        end
    end

    assign cell_out = s5_reg;

endmodule

@@ rtl/fcvl_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// fcvl_sqrt_cell
// One digit of the integer square root: takes two operand bits, decides one
// root bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module fcvl_sqrt_cell (
    input  logic            clk,
    input  logic            en,
    input  fcvl_pkg::cell_t cell_in,
    output fcvl_pkg::cell_t cell_out
);

    logic [fcvl_pkg::REM_WIDTH-1:0] rem_sh, trial;
    fcvl_pkg::cell_t cell_reg, cell_next;

    always_comb
    begin
        rem_sh = {cell_in.rem[fcvl_pkg::REM_WIDTH-3:0],
                  cell_in.x[fcvl_pkg::PROD_WIDTH-1 -: 2]};
        trial  = {1'b0, cell_in.root, 2'b01};
        cell_next      = cell_in;
        cell_next.x    = {cell_in.x[fcvl_pkg::PROD_WIDTH-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[fcvl_pkg::ROOT_WIDTH-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[fcvl_pkg::ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

@@ rtl/foc_cross_coupling_voltage_limit.sv @@
// ----------------------------------------------------------------------------
// foc_cross_coupling_voltage_limit
// Induction-motor dq decoupling with a d-priority stator voltage limit.
// ----------------------------------------------------------------------------
// Input words arrive on item_valid/item_stall and carry the regulator
// references, currents, speeds and the voltage limit. Each word yields one
// output word on result_valid/result_stall with the limited stator voltages,
// the magnitude and the overload flag.
// The three gains are written on the cfg_valid/cfg_ready port, which is
// always ready; writes are expected only while the block is empty.
// The pipeline has five compensation and squaring stages, a row of 24
// square-root cells resolving one root bit each, and the output register.
// A new word is accepted every cycle while item_stall is low, so throughput is one word per cycle.
// Every stage holds its own valid bit and only stalls when the stage after
// it is full and stalled, so bubbles close up while the receiver stalls.
// item_stall rises only once the whole pipeline is full behind a stalled
// output word.
// Reset clears all valid bits and the gain registers to zero.
// ----------------------------------------------------------------------------
module foc_cross_coupling_voltage_limit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [23:0]            cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic signed [23:0]     ref_volt_d,
    input  logic signed [23:0]     ref_volt_q,
    input  logic signed [23:0]     cur_d,
    input  logic signed [23:0]     cur_q,
    input  logic signed [23:0]     flux_cur,
    input  logic signed [23:0]     elec_speed,
    input  logic signed [23:0]     slip_speed,
    input  logic [22:0]            volt_limit,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic signed [23:0]     stator_volt_d,
    output logic signed [23:0]     stator_volt_q,
    output logic [22:0]            volt_magnitude,
    output logic                   overload
);

    localparam int NS = fcvl_pkg::STAGE_COUNT;
    localparam int FS = fcvl_pkg::FRONT_STAGES;
    localparam int NC = fcvl_pkg::CELL_COUNT;

    fcvl_pkg::word_t flux_gain_reg, cross_gain_reg, slip_gain_reg;
    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;
    fcvl_pkg::cell_t cells [NC+1];

    fcvl_pkg::word_t out_d_reg, out_q_reg, out_d_next, out_q_next;
    fcvl_pkg::mag_t  out_mag_reg, out_mag_next;
    logic            out_ovl_reg;
    fcvl_pkg::meta_t last_meta;
    fcvl_pkg::word_t root_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flux_gain_reg  <= '0;
            cross_gain_reg <= '0;
            slip_gain_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fcvl_pkg::reg_index_t'(cfg_index))
                fcvl_pkg::REG_FLUX_GAIN:  flux_gain_reg  <= cfg_data;
                fcvl_pkg::REG_CROSS_GAIN: cross_gain_reg <= cfg_data;
                fcvl_pkg::REG_SLIP_GAIN:  slip_gain_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        en[NS] = !result_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign item_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= (k == 0) ? item_valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    fcvl_front u_front (
        .clk        (clk),
        .en         (en[FS-1:0]),
        .flux_gain  (flux_gain_reg),
        .cross_gain (cross_gain_reg),
        .slip_gain  (slip_gain_reg),
        .ref_volt_d (ref_volt_d),
        .ref_volt_q (ref_volt_q),
        .cur_d      (cur_d),
        .cur_q      (cur_q),
        .flux_cur   (flux_cur),
        .elec_speed (elec_speed),
        .slip_speed (slip_speed),
        .volt_limit (volt_limit),
        .cell_out   (cells[0])
    );

    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        fcvl_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en[FS+g]),
            .cell_in  (cells[g]),
            .cell_out (cells[g+1])
        );
    end

    always_comb
    begin
        last_meta = cells[NC].meta;
        root_word = cells[NC].root;
        if (!last_meta.ovl)
        begin
            out_d_next   = last_meta.usd;
            out_q_next   = last_meta.usq;
            out_mag_next = cells[NC].root[fcvl_pkg::MAG_WIDTH-1:0];
        end
        else if (last_meta.dclamp)
        begin
            if (last_meta.usd > 0)
            begin
                out_d_next = 24'(last_meta.lim);
            end
            else if (last_meta.usd < 0)
            begin
                out_d_next = -24'(last_meta.lim);
            end
            else
            begin
                out_d_next = '0;
            end
            out_q_next   = '0;
            out_mag_next = last_meta.lim;
        end
        else
        begin
            out_d_next   = last_meta.usd;
            out_q_next   = last_meta.usq[fcvl_pkg::DATA_WIDTH-1] ? -root_word : root_word;
            out_mag_next = last_meta.lim;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            out_d_reg   <= out_d_next;
            out_q_reg   <= out_q_next;
            out_mag_reg <= out_mag_next;
            out_ovl_reg <= last_meta.ovl;
        end
    end

    assign result_valid   = valid_reg[NS-1];
    assign stator_volt_d  = out_d_reg;
    assign stator_volt_q  = out_q_reg;
    assign volt_magnitude = out_mag_reg;
    assign overload       = out_ovl_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (&valid_reg) && result_stall)
        else $error("input stalled while the pipeline has room");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS-2] && en[NS-1]) |=> result_valid)
        else $error("word lost between last cell and output register");

    a_q_needs_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overload && stator_volt_q != 0) |-> volt_magnitude != 0)
        else $error("nonzero q voltage under a zero limit");

endmodule
